[design/spikat_pkg.sv]
// Package for the keyed association table.
// Holds the opcode, status and sequencer state types; depends on nothing.
`timescale 1ns / 1ps

package spikat_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_MISS = 3'd1,
    ST_DUP  = 3'd2,
    ST_FULL = 3'd3,
    ST_ZERO = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FIN
  } state_e;

endpackage

[design/spi_keyed_association_table.sv]
// Top level of the keyed association table: key store, payload memory and sequencer.
// Depends on spikat_pkg for opcode, status and state types.
`timescale 1ns / 1ps
//
// Each request on the slave stream carries an opcode in tuser and a key with a
// record word in tdata. It inserts, deletes or looks up the key. Exactly one
// result leaves on the master stream: a status code in tuser and the record in
// tdata, which is zero unless a lookup hit.
// A request is registered at acceptance, compared against all stored keys in
// the next cycle, and the payload memory is written or read in that cycle. The
// memory read data is registered and used in the finish state, where the result
// is loaded into the output register once that register is free. A new request
// is taken in the same cycle that the previous result is loaded, never earlier.
// While a result waits in the output register the next request is still
// accepted and processed; its result is held until the output register frees.
// Reset empties the table and clears the last-hit register; the key store and
// payload memory contents are not cleared, as only valid entries are read.

module spi_keyed_association_table
  import spikat_pkg::*;
#(
  parameter int ENTRIES     = 16,
  parameter int KEY_BITS    = 32,
  parameter int RECORD_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,  // spi [31:0], payload_in [95:32]
  input  logic [1:0]   s_axis_tuser_i,  // opcode [1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,  // payload_out [63:0]
  output logic [2:0]   m_axis_tuser_o   // status [2:0]
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_e state_q, state_d;
  logic   s_accept, look_en, fin_en, out_free;

  op_e                    req_op_q;
  logic [KEY_BITS-1:0]    req_key_q;
  logic [RECORD_BITS-1:0] req_rec_q;

  logic [ENTRIES-1:0]     valid_q;
  logic [KEY_BITS-1:0]    ent_key_q [ENTRIES];
  logic [RECORD_BITS-1:0] pay_mem [ENTRIES];
  logic [RECORD_BITS-1:0] rdata_q;

  logic [KEY_BITS-1:0]    recent_key_q;
  logic [RECORD_BITS-1:0] recent_pay_q;

  status_e                res_status_q, res_status_d;
  logic [RECORD_BITS-1:0] res_data_q, res_data_d;
  logic                   res_mem_q, res_mem_d;

  logic                   out_valid_q;
  status_e                out_status_q;
  logic [63:0]            out_data_q;

  logic [ENTRIES-1:0] match;
  logic               hit, full, key_zero, recent_match;
  logic [IDX_W-1:0]   hit_idx, free_idx;
  logic               mem_we, mem_re, clr_en, flush_en;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d = s_accept ? S_LOOK : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    look_en         = 1'b0;
    fin_en          = 1'b0;
    unique case (state_q)
      S_IDLE: s_axis_tready_o = 1'b1;
      S_LOOK: look_en = 1'b1;
      S_FIN: begin
        fin_en          = out_free;
        s_axis_tready_o = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_op_q  <= op_e'(s_axis_tuser_i);
      req_key_q <= KEY_BITS'(s_axis_tdata_i[31:0]);
      req_rec_q <= RECORD_BITS'(s_axis_tdata_i[95:32]);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (ent_key_q[i] == req_key_q);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit          = |match;
    full         = &valid_q;
    key_zero     = (req_key_q == '0);
    recent_match = !key_zero && (recent_key_q == req_key_q);
  end

  always_comb begin
    res_status_d = ST_MISS;
    res_data_d   = '0;
    res_mem_d    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    clr_en       = 1'b0;
    flush_en     = 1'b0;
    case (req_op_q)
      OP_INSERT: begin
        if (key_zero) begin
          res_status_d = ST_ZERO;
        end else if (hit) begin
          res_status_d = ST_DUP;
        end else if (full) begin
          res_status_d = ST_FULL;
        end else begin
          res_status_d = ST_OK;
          mem_we       = 1'b1;
        end
      end
      OP_DELETE: begin
        if (!key_zero && hit) begin
          res_status_d = ST_OK;
          clr_en       = 1'b1;
        end
        flush_en = recent_match;
      end
      OP_LOOKUP: begin
        if (recent_match) begin
          res_status_d = ST_OK;
          res_data_d   = recent_pay_q;
        end else if (!key_zero && hit) begin
          res_status_d = ST_OK;
          res_mem_d    = 1'b1;
          mem_re       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (look_en && mem_we) begin
      pay_mem[free_idx]   <= req_rec_q;
      ent_key_q[free_idx] <= req_key_q;
    end
    if (look_en && mem_re) begin
      rdata_q <= pay_mem[hit_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      recent_key_q <= '0;
      recent_pay_q <= '0;
      res_mem_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (look_en) begin
        res_mem_q <= res_mem_d;
        if (mem_we) begin
          valid_q[free_idx] <= 1'b1;
        end
        if (clr_en) begin
          valid_q[hit_idx] <= 1'b0;
        end
        if (flush_en) begin
          recent_key_q <= '0;
          recent_pay_q <= '0;
        end
      end
      if (fin_en && res_mem_q) begin
        recent_key_q <= req_key_q;
        recent_pay_q <= rdata_q;
      end
      if (fin_en) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_en) begin
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
    end
    if (fin_en) begin
      out_status_q <= res_status_q;
      out_data_q   <= 64'(res_mem_q ? rdata_q : res_data_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  a_no_accept_in_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |-> state_q != S_LOOK)
    else $error("request accepted during the compare cycle");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    look_en |-> $countones(match) <= 1)
    else $error("key stored in more than one valid entry");

  a_zero_key_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (look_en && req_op_q == OP_LOOKUP && key_zero) |=> res_status_q == ST_MISS)
    else $error("lookup of the reserved key did not miss");

  a_load_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result loaded outside the finish cycle");

endmodule
